// ----- hdl/dsec_pkg.sv -----
// ----------------------------------------------------------------------------
// dsec_pkg: shared types and constants for the debounced step encoder counter
// Field widths, reset values and the encoder / step codes used by all files.
// ----------------------------------------------------------------------------
`default_nettype none

package dsec_pkg;

	// Field widths
	localparam int LEVELS_W = 8;
	localparam int SAMPLE_W = 4;
	localparam int COUNT_W  = 10;
	localparam int STEP_W   = 3;

	// Parameter defaults
	localparam int NUM_BUTTONS_DEF  = 8;
	localparam int DEBOUNCE_LEN_DEF = 12;

	typedef logic [LEVELS_W-1:0] levels_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [STEP_W-1:0]   step_t;

	// Reset values
	localparam count_t MAX_COUNT_RST = count_t'(1023);
	localparam step_t  STEP_RST      = step_t'(1);

	// Step size codes
	localparam step_t STEP_KEEP_MASK = step_t'(6);  // clears bit 0
	localparam step_t STEP_BTN0_FLIP = step_t'(2);
	localparam step_t STEP_BTN1_FLIP = step_t'(4);
	localparam step_t STEP_ZERO      = step_t'(0);
	localparam step_t STEP_MIN       = step_t'(1);
	localparam step_t STEP_FOLD      = step_t'(6);  // folds back to zero

	// Quadrature phase codes
	localparam logic [1:0] ENC_FWD  = 2'b10;
	localparam logic [1:0] ENC_REV  = 2'b01;
	localparam logic [1:0] ENC_REST = 2'b00;

endpackage

`default_nettype wire

// ----- hdl/dsec_debounce.sv -----
// ----------------------------------------------------------------------------
// dsec_debounce: shift-history button debouncer
// Keeps one history per button and flags a press when the shifted history
// shows a single release level followed by DEBOUNCE_LEN pressed levels.
// ----------------------------------------------------------------------------
`default_nettype none

module dsec_debounce #(
	parameter int NUM_BUTTONS  = dsec_pkg::NUM_BUTTONS_DEF,
	parameter int DEBOUNCE_LEN = dsec_pkg::DEBOUNCE_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift_en,
	input  wire dsec_pkg::levels_t levels,
	output logic [NUM_BUTTONS-1:0] press
);
	import dsec_pkg::*;

	localparam int HIST_W = DEBOUNCE_LEN + 1;
	localparam logic [HIST_W-1:0] PRESS_PATTERN = {1'b1, {DEBOUNCE_LEN{1'b0}}};

	logic [HIST_W-1:0] hist_q [NUM_BUTTONS];

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		logic              lvl;
		logic [HIST_W-1:0] hist_next;

		// buttons with no bit in the field read as released
		if (i < LEVELS_W) begin : g_lvl
			assign lvl = levels[i];
		end else begin : g_idle
			assign lvl = 1'b1;
		end

		assign hist_next = {hist_q[i][DEBOUNCE_LEN-1:0], lvl};
		assign press[i]  = (hist_next == PRESS_PATTERN);

		// history shift on each scan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[i] <= '1;
			end else if (shift_en) begin
				hist_q[i] <= hist_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/debounced_step_encoder_counter.sv -----
// ----------------------------------------------------------------------------
// debounced_step_encoder_counter: two-encoder position counter with buttons
// Debounced buttons set the step size; two quadrature encoders move the
// count by that step, wrapping between zero and max_count.
// ----------------------------------------------------------------------------
//  channel  signals                                        direction
//  in       in_valid/in_stall, scan_tick, button_levels,   into block
//           encoder_sample
//  out      out_valid/out_stall, count, step               out of block
//  cfg      cfg_wr_en, cfg_wr_data (max_count)             into block
//
//  One request per clock sustained while out_stall stays low; a request
//  passes the input register, then the result register, on its way to out.
//  The state update and result register share one stage, so the next
//  request sees this one's step size and position directly.
//  in_stall rises only while a request waits in the input register and the
//  result register is held by out_stall.
//  Reset: count 0, step 1, max_count 1023, buttons released.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_step_encoder_counter #(
	parameter int NUM_BUTTONS  = dsec_pkg::NUM_BUTTONS_DEF,
	parameter int DEBOUNCE_LEN = dsec_pkg::DEBOUNCE_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_wr_en,
	input  wire dsec_pkg::count_t  cfg_wr_data,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              scan_tick,
	input  wire dsec_pkg::levels_t button_levels,
	input  wire dsec_pkg::sample_t encoder_sample,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dsec_pkg::count_t       count,
	output dsec_pkg::step_t        step
);
	import dsec_pkg::*;

	localparam int SUM_W = COUNT_W + 2;

	// input register
	logic    valid_s1;
	logic    tick_s1;
	levels_t levels_s1;
	sample_t sample_s1;

	// state and result register
	logic    out_valid_q;
	count_t  position_q;
	step_t   step_size_q;
	sample_t last_sample_q;
	count_t  max_count_q;

	logic                    advance;
	logic [NUM_BUTTONS-1:0]  press_raw;
	logic [NUM_BUTTONS-1:0]  press;
	logic                    press_other;
	step_t                   step_next;
	logic signed [SUM_W-1:0] delta_l;
	logic signed [SUM_W-1:0] delta_r;
	logic signed [SUM_W-1:0] pos_sum;
	count_t                  position_next;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			tick_s1   <= scan_tick;
			levels_s1 <= button_levels;
			sample_s1 <= encoder_sample;
		end
	end

	// button debounce
	dsec_debounce #(
		.NUM_BUTTONS  (NUM_BUTTONS),
		.DEBOUNCE_LEN (DEBOUNCE_LEN)
	) u_debounce (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (advance && tick_s1),
		.levels   (levels_s1),
		.press    (press_raw)
	);

	assign press       = tick_s1 ? press_raw : '0;
	assign press_other = |(press >> 2);

	// step size: button 0, then button 1, then the rest
	always_comb begin
		step_next = step_size_q;
		if (press[0]) begin
			step_next = (step_next & STEP_KEEP_MASK) ^ STEP_BTN0_FLIP;
			if (step_next == STEP_ZERO) begin
				step_next = STEP_MIN;
			end
		end
		if (press[1]) begin
			step_next = (step_next & STEP_KEEP_MASK) ^ STEP_BTN1_FLIP;
			if (step_next == STEP_ZERO) begin
				step_next = STEP_MIN;
			end
		end
		if (press_other) begin
			step_next = step_next & STEP_KEEP_MASK;
		end
		if (step_next == STEP_FOLD) begin
			step_next = STEP_ZERO;
		end
	end

	// encoder detents
	always_comb begin
		delta_l = '0;
		delta_r = '0;
		if (sample_s1[1:0] == ENC_REST) begin
			if (last_sample_q[1:0] == ENC_FWD) begin
				delta_l = $signed(SUM_W'(step_next));
			end else if (last_sample_q[1:0] == ENC_REV) begin
				delta_l = -$signed(SUM_W'(step_next));
			end
		end
		if (sample_s1[3:2] == ENC_REST) begin
			if (last_sample_q[3:2] == ENC_FWD) begin
				delta_r = $signed(SUM_W'(step_next));
			end else if (last_sample_q[3:2] == ENC_REV) begin
				delta_r = -$signed(SUM_W'(step_next));
			end
		end
	end

	// position with wrap
	assign pos_sum = $signed(SUM_W'(position_q)) + delta_l + delta_r;

	always_comb begin
		priority if (pos_sum > $signed(SUM_W'(max_count_q))) begin
			position_next = '0;
		end else if (pos_sum < 0) begin
			position_next = max_count_q;
		end else begin
			position_next = pos_sum[COUNT_W-1:0];
		end
	end

	// state and result update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			position_q    <= '0;
			step_size_q   <= STEP_RST;
			last_sample_q <= '0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				position_q    <= position_next;
				step_size_q   <= step_next;
				last_sample_q <= sample_s1;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= MAX_COUNT_RST;
		end else if (cfg_wr_en) begin
			max_count_q <= cfg_wr_data;
		end
	end

	assign out_valid = out_valid_q;
	assign count     = position_q;
	assign step      = step_size_q;

endmodule

`default_nettype wire

// ----- hdl/dsec_checker.sv -----
// ----------------------------------------------------------------------------
// dsec_checker: port-level checks for the debounced step encoder counter
// Watches the top level's ports and is attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dsec_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire dsec_pkg::count_t  count,
	input wire dsec_pkg::step_t   step
);
	import dsec_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count) && $stable(step))
		else $error("held result changed");

	// input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a held result");

	// a step of six always folds back to zero
	a_step_fold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step != STEP_FOLD)
		else $error("step size six reached the output");

	// a result only appears for an accepted request, through the input and result registers
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a request");

endmodule

bind debounced_step_encoder_counter dsec_checker u_dsec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.count     (count),
	.step      (step)
);

`default_nettype wire

// ----- tb/tb_debounced_step_encoder_counter.sv -----
// ----------------------------------------------------------------------------
// tb_debounced_step_encoder_counter: self-checking bench for the step counter
// Walks a short table of directed passes, then random passes over several
// max_count settings. Button groups are held low for random runs of scans,
// at times long enough to debounce, and both encoders step through real
// detents. Every result is checked against a cycle-free model of the counter
// kept inside the bench. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_debounced_step_encoder_counter;
	import dsec_pkg::*;

	localparam int     BTN_N     = 8;
	localparam int     DB_LEN    = 12;
	localparam int     DIR_N     = 23;
	localparam int     RAND_N    = 88;
	localparam int     SET_N     = 8;
	localparam int     SHOW_MAX  = 10;
	localparam [DB_LEN:0] PRESS_SEEN = {1'b1, {DB_LEN{1'b0}}};

	// one reading of the counter
	typedef struct packed {
		count_t cnt;
		step_t  stp;
	} reading_t;

	// directed row; fixed readings apply where known is set
	typedef struct packed {
		logic    scan;
		levels_t lv;
		sample_t smp;
		logic    known;
		count_t  cnt;
		step_t   stp;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{1'b0, 8'hFF, {ENC_REST, ENC_REST}, 1'b1, 10'd0,    3'd1},
		'{1'b0, 8'hFF, {ENC_REST, ENC_FWD},  1'b1, 10'd0,    3'd1},
		'{1'b0, 8'hFF, {ENC_REST, ENC_REST}, 1'b1, 10'd1,    3'd1},
		'{1'b0, 8'hFF, {ENC_REST, ENC_REV},  1'b1, 10'd1,    3'd1},
		'{1'b0, 8'hFF, {ENC_REST, ENC_REST}, 1'b1, 10'd0,    3'd1},
		'{1'b0, 8'hFF, {ENC_REV,  ENC_REST}, 1'b1, 10'd0,    3'd1},
		'{1'b0, 8'hFF, {ENC_REST, ENC_REST}, 1'b1, 10'd1023, 3'd1},
		'{1'b0, 8'hFF, {ENC_FWD,  ENC_FWD},  1'b1, 10'd1023, 3'd1},
		'{1'b0, 8'hFF, {ENC_REST, ENC_REST}, 1'b1, 10'd0,    3'd1},
		// buttons 0 and 7 held low for a full debounce window
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b0, 10'd0,    3'd0},
		'{1'b1, 8'h7E, {ENC_REST, ENC_REST}, 1'b1, 10'd0,    3'd2},
		// all-low levels, first with both encoders at 11
		'{1'b1, 8'h00, {2'b11,    2'b11},    1'b0, 10'd0,    3'd0},
		'{1'b0, 8'h00, {ENC_FWD,  ENC_REV},  1'b0, 10'd0,    3'd0}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_wr_en = 1'b0;
	count_t  cfg_wr_data = '0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	logic    scan_tick = 1'b0;
	levels_t button_levels = '0;
	sample_t encoder_sample = '0;
	logic    out_valid;
	logic    out_stall = 1'b1;
	count_t  count;
	step_t   step;

	// model state
	logic [DB_LEN:0] btn_hist [BTN_N];
	sample_t prev_smp;
	step_t   cur_step;
	count_t  cur_pos;
	count_t  lim;

	reading_t due_readings [$];
	int n_sent = 0;
	int n_checked = 0;
	int n_bad = 0;
	int n_press = 0;
	int n_wrap = 0;
	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;

	debounced_step_encoder_counter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.scan_tick     (scan_tick),
		.button_levels (button_levels),
		.encoder_sample(encoder_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.count         (count),
		.step          (step)
	);

	always #5 clk = ~clk;

	// signed move of one encoder for one pass
	function automatic int detent_move(logic [1:0] was, logic [1:0] now, step_t amt);
		if (now == ENC_REST && was == ENC_FWD)
			return int'(amt);
		if (now == ENC_REST && was == ENC_REV)
			return -int'(amt);
		return 0;
	endfunction

	// advance the counter model by one pass and give the reading
	task automatic track_pass(input logic sc, input levels_t lv, input sample_t smp,
			output reading_t rd);
		int p;
		if (sc) begin
			for (int i = 0; i < BTN_N; i++) begin
				btn_hist[i] = {btn_hist[i][DB_LEN-1:0], lv[i]};
				if (btn_hist[i] == PRESS_SEEN) begin
					n_press++;
					cur_step = cur_step & STEP_KEEP_MASK;
					if (i == 0) begin
						cur_step = cur_step ^ STEP_BTN0_FLIP;
						if (cur_step == STEP_ZERO)
							cur_step = STEP_MIN;
					end else if (i == 1) begin
						cur_step = cur_step ^ STEP_BTN1_FLIP;
						if (cur_step == STEP_ZERO)
							cur_step = STEP_MIN;
					end
				end
			end
		end
		if (cur_step == STEP_FOLD)
			cur_step = STEP_ZERO;
		p = int'(cur_pos) + detent_move(prev_smp[1:0], smp[1:0], cur_step)
			+ detent_move(prev_smp[3:2], smp[3:2], cur_step);
		prev_smp = smp;
		if (p > int'(lim)) begin
			p = 0;
			n_wrap++;
		end
		if (p < 0) begin
			p = int'(lim);
			n_wrap++;
		end
		cur_pos = count_t'(p);
		rd.cnt = cur_pos;
		rd.stp = cur_step;
	endtask

	task automatic note_bad(input string msg);
		n_bad++;
		if (n_bad <= SHOW_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	// offer one request, wait for it to be taken, log its reading
	task automatic send_pass(input logic sc, input levels_t lv, input sample_t smp,
			input logic known, input reading_t fixed);
		int gap;
		reading_t rd;
		gap = in_idle_en ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		scan_tick <= sc;
		button_levels <= lv;
		encoder_sample <= smp;
		do @(posedge clk); while (in_stall);
		track_pass(sc, lv, smp, rd);
		due_readings.push_back(known ? fixed : rd);
		n_sent++;
		if ($urandom_range(0, 31) == 0)
			in_idle_en = !in_idle_en;
	endtask

	// write max_count once the block has drained
	task automatic set_limit(input count_t v);
		in_valid <= 1'b0;
		while (due_readings.size() != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lim = v;
	endtask

	// one encoder phase pair, biased toward detents
	function automatic logic [1:0] pick_phase();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return ENC_REST;
		if (r < 7)
			return ENC_FWD;
		if (r < 9)
			return ENC_REV;
		return 2'b11;
	endfunction

	// result side: random stall, then check each accepted result
	initial begin
		int hold;
		reading_t want;
		forever begin
			hold = out_idle_en ? $urandom_range(0, 11) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (due_readings.size() == 0) begin
				note_bad($sformatf("result with nothing due: count %0d step %0d",
					count, step));
			end else begin
				want = due_readings.pop_front();
				n_checked++;
				if (count !== want.cnt)
					note_bad($sformatf("count: expected %0d, got %0d", want.cnt, count));
				if (step !== want.stp)
					note_bad($sformatf("step: expected %0d, got %0d", want.stp, step));
			end
			if ($urandom_range(0, 31) == 0)
				out_idle_en = !out_idle_en;
		end
	end

	// stimulus
	initial begin
		count_t   limits [SET_N];
		reading_t fixed;
		levels_t  btn_low;
		levels_t  lv;
		int       btn_left;
		int       r;
		logic     sc;

		for (int i = 0; i < BTN_N; i++)
			btn_hist[i] = '1;
		prev_smp = '0;
		cur_step = STEP_RST;
		cur_pos = '0;
		lim = MAX_COUNT_RST;
		btn_low = '0;
		btn_left = 0;

		limits[0] = count_t'(1023);
		limits[1] = count_t'(0);
		limits[2] = count_t'(1);
		limits[3] = count_t'(7);
		limits[4] = count_t'(300);
		limits[5] = count_t'($urandom_range(2, 1022));
		limits[6] = count_t'(2);
		limits[7] = count_t'(1023);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset value of max_count
		foreach (DIR_TAB[k]) begin
			fixed.cnt = DIR_TAB[k].cnt;
			fixed.stp = DIR_TAB[k].stp;
			send_pass(DIR_TAB[k].scan, DIR_TAB[k].lv, DIR_TAB[k].smp,
				DIR_TAB[k].known, fixed);
		end

		// random passes, one block per max_count setting
		fixed = '0;
		for (int s = 0; s < SET_N; s++) begin
			set_limit(limits[s]);
			for (int n = 0; n < RAND_N; n++) begin
				sc = ($urandom_range(0, 2) != 0);
				if (sc) begin
					// hold a button group low, then move to another one
					if (btn_left == 0) begin
						r = $urandom_range(0, 9);
						if (r < 4)
							btn_low = '0;
						else if (r < 6)
							btn_low = 8'h01;
						else if (r < 8)
							btn_low = 8'h02;
						else if (r < 9)
							btn_low = 8'h03 | levels_t'($urandom_range(0, 255));
						else
							btn_low = levels_t'($urandom_range(0, 255));
						btn_left = $urandom_range(4, 20);
					end
					btn_left--;
					lv = ~btn_low;
					// occasional contact bounce
					if ($urandom_range(0, 15) == 0)
						lv[$urandom_range(0, 7)] ^= 1'b1;
				end else begin
					lv = levels_t'($urandom_range(0, 255));
				end
				send_pass(sc, lv, {pick_phase(), pick_phase()}, 1'b0, fixed);
			end
		end

		in_valid <= 1'b0;
		while (due_readings.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d passes sent, %0d results checked, %0d mismatches",
			n_sent, n_checked, n_bad);
		$display("%0d max_count settings, %0d debounced presses, %0d wraps",
			SET_N, n_press, n_wrap);
		if (n_bad == 0 && due_readings.size() == 0)
			$display("tb_debounced_step_encoder_counter passed");
		else
			$display("tb_debounced_step_encoder_counter failed");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout with %0d results still due", due_readings.size());
		$display("tb_debounced_step_encoder_counter failed");
		$finish;
	end

endmodule

// ----- debounced_step_encoder_counter.f -----
hdl/dsec_pkg.sv
hdl/dsec_debounce.sv
hdl/debounced_step_encoder_counter.sv
hdl/dsec_checker.sv
tb/tb_debounced_step_encoder_counter.sv
